// ===== hw/rtl/lsno_pkg.sv =====
// Shared types and constants for the lidar nearest-obstacle scan reducer.
// No dependencies; every other file in hw/rtl imports this package.
package lsno_pkg;

	localparam int MAX_POINTS  = 4096;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int RANGE_W     = 16;
	localparam int STEP_W      = 25;
	localparam int ANGLE_W     = IDX_W + STEP_W;
	localparam int SUM_W       = RANGE_W + IDX_W;
	localparam int DSTEP_W     = $clog2(SUM_W);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 2;

	// Front cone limits, degrees in Q16
	localparam logic [ANGLE_W-1:0] CONE_LOW  = ANGLE_W'(64'd15 << 16);
	localparam logic [ANGLE_W-1:0] CONE_HIGH = ANGLE_W'(64'd345 << 16);

	localparam logic [RANGE_W-1:0] RST_MIN_RANGE = RANGE_W'(0);
	localparam logic [RANGE_W-1:0] RST_MAX_RANGE = RANGE_W'(12000);
	localparam logic [STEP_W-1:0]  RST_STEP      = STEP_W'(65536);
	localparam logic [RANGE_W-1:0] RST_DANGER    = RANGE_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_RANGE  = 2'd0,
		CFG_MAX_RANGE  = 2'd1,
		CFG_ANGLE_STEP = 2'd2,
		CFG_DANGER     = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic [RANGE_W-1:0] min_valid_range;
		logic [RANGE_W-1:0] max_valid_range;
		logic [STEP_W-1:0]  angle_step;
		logic [RANGE_W-1:0] danger_distance;
	} cfg_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range_mm;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic               nearest_found;
		logic [RANGE_W-1:0] nearest_range;
		logic [IDX_W-1:0]   nearest_index;
		logic               front_found;
		logic [RANGE_W-1:0] front_range;
		logic [IDX_W-1:0]   front_index;
		logic               danger;
		logic [CNT_W-1:0]   valid_count;
		logic [RANGE_W-1:0] mean_range;
		logic [CNT_W-1:0]   point_count;
	} out_item_t;

	// Classified sample handed from the front end to the accumulator
	typedef struct packed {
		logic [RANGE_W-1:0] range_mm;
		logic [IDX_W-1:0]   idx;
		logic               valid;
		logic               front;
		logic               last;
		logic [CNT_W-1:0]   count;
	} q_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic idle;
		logic done;
	} div_status_t;

endpackage

// ===== hw/rtl/lsno_front.sv =====
// Front end: accepts range samples, numbers them, and classifies each one
// (range window, front cone). Depends on lsno_pkg.
module lsno_front import lsno_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	input  cfg_t      cfg,
	input  q_status_t q_status,
	output logic      q_push,
	output q_item_t   q_item
);

	logic [CNT_W-1:0]   sample_q;
	logic [CNT_W-1:0]   count_next;
	logic [IDX_W-1:0]   idx;
	logic [ANGLE_W-1:0] angle;

	assign in_stall = q_status.full;
	assign q_push   = in_valid && !q_status.full;

	assign idx = (sample_q < CNT_W'(MAX_POINTS - 1)) ? sample_q[IDX_W-1:0]
		: IDX_W'(MAX_POINTS - 1);
	assign count_next = (sample_q < CNT_W'(MAX_POINTS)) ? sample_q + CNT_W'(1) : sample_q;
	assign angle = ANGLE_W'(idx) * ANGLE_W'(cfg.angle_step);

	always_comb begin
		q_item.range_mm = in_data.range_mm;
		q_item.idx      = idx;
		q_item.valid    = (in_data.range_mm >= cfg.min_valid_range)
			&& (in_data.range_mm <= cfg.max_valid_range);
		q_item.front    = (angle < CONE_LOW) || (angle > CONE_HIGH);
		q_item.last     = in_data.last;
		q_item.count    = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (q_push) begin
			sample_q <= in_data.last ? '0 : count_next;
		end
	end

endmodule

// ===== hw/rtl/lsno_fifo.sv =====
// Short queue of classified samples between front end and accumulator.
// Depends on lsno_pkg.
module lsno_fifo import lsno_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_item_t   push_item,
	input  logic      pop,
	output q_item_t   pop_item,
	output q_status_t status
);

	q_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign status.empty = (fill_q == '0);
	assign status.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lsno_div.sv =====
// Restoring divider for the mean range: one quotient bit per cycle.
// Depends on lsno_pkg.
module lsno_div import lsno_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]   divisor,
	input  logic               ack,
	output div_status_t        status,
	output logic [RANGE_W-1:0] quotient
);

	div_state_t         state_q, state_d;
	logic [CNT_W:0]     rem_q;
	logic [SUM_W-1:0]   dq_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [DSTEP_W-1:0] step_q;
	logic [CNT_W:0]     rem_sh;
	logic               ge;

	assign rem_sh = {rem_q[CNT_W-1:0], dq_q[SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	// An empty scan gives a mean of zero
	assign quotient = (dvs_q == '0) ? '0 : dq_q[RANGE_W-1:0];

	always_comb begin
		state_d     = state_q;
		status.idle = 1'b0;
		status.done = 1'b0;
		case (state_q)
			DIV_IDLE: begin
				status.idle = 1'b1;
				if (start) begin
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (step_q == DSTEP_W'(SUM_W - 1)) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: begin
				status.done = 1'b1;
				if (ack) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			dq_q   <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == DIV_RUN) begin
			rem_q  <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dq_q   <= {dq_q[SUM_W-2:0], ge};
			step_q <= step_q + DSTEP_W'(1);
		end
	end

endmodule

// ===== hw/rtl/lsno_back.sv =====
// Back end: folds classified samples into the scan minima and sums, closes
// the scan on the last sample and drives the result register.
// Depends on lsno_pkg and lsno_div.
module lsno_back import lsno_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  q_item_t            q_item,
	input  q_status_t          q_status,
	output logic               q_pop,
	input  logic [RANGE_W-1:0] danger_distance,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	logic [RANGE_W-1:0] best_range_q, best_range_n;
	logic [IDX_W-1:0]   best_index_q, best_index_n;
	logic               best_valid_q, best_valid_n;
	logic [RANGE_W-1:0] cone_range_q, cone_range_n;
	logic [IDX_W-1:0]   cone_index_q, cone_index_n;
	logic               cone_valid_q, cone_valid_n;
	logic [SUM_W-1:0]   sum_q, sum_n;
	logic [CNT_W-1:0]   total_q, total_n;
	logic               best_take, cone_take, cnt_take;
	out_item_t          hold_q;
	out_item_t          result_d;
	out_item_t          out_data_q;
	logic               out_valid_q;
	logic               div_start;
	logic               load;
	div_status_t        div_status;
	logic [RANGE_W-1:0] quotient;

	// A closing sample waits for the divider to be free
	assign q_pop     = !q_status.empty && (!q_item.last || div_status.idle);
	assign div_start = q_pop && q_item.last;
	assign load      = div_status.done && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		best_take = q_item.valid && (!best_valid_q || q_item.range_mm < best_range_q);
		cone_take = q_item.valid && q_item.front
			&& (!cone_valid_q || q_item.range_mm < cone_range_q);
		cnt_take  = q_item.valid && (total_q < CNT_W'(MAX_POINTS));

		best_range_n = best_take ? q_item.range_mm : best_range_q;
		best_index_n = best_take ? q_item.idx : best_index_q;
		best_valid_n = best_valid_q || best_take;
		cone_range_n = cone_take ? q_item.range_mm : cone_range_q;
		cone_index_n = cone_take ? q_item.idx : cone_index_q;
		cone_valid_n = cone_valid_q || cone_take;
		sum_n        = cnt_take ? sum_q + SUM_W'(q_item.range_mm) : sum_q;
		total_n      = cnt_take ? total_q + CNT_W'(1) : total_q;
	end

	always_comb begin
		result_d            = hold_q;
		result_d.mean_range = quotient;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_range_q <= '0;
			best_index_q <= '0;
			best_valid_q <= 1'b0;
			cone_range_q <= '0;
			cone_index_q <= '0;
			cone_valid_q <= 1'b0;
			sum_q        <= '0;
			total_q      <= '0;
		end else if (q_pop) begin
			if (q_item.last) begin
				best_range_q <= '0;
				best_index_q <= '0;
				best_valid_q <= 1'b0;
				cone_range_q <= '0;
				cone_index_q <= '0;
				cone_valid_q <= 1'b0;
				sum_q        <= '0;
				total_q      <= '0;
			end else begin
				best_range_q <= best_range_n;
				best_index_q <= best_index_n;
				best_valid_q <= best_valid_n;
				cone_range_q <= cone_range_n;
				cone_index_q <= cone_index_n;
				cone_valid_q <= cone_valid_n;
				sum_q        <= sum_n;
				total_q      <= total_n;
			end
		end
	end

	// Hold the closed scan while the mean is computed
	always_ff @(posedge clk) begin
		if (div_start) begin
			hold_q.nearest_found <= best_valid_n;
			hold_q.nearest_range <= best_valid_n ? best_range_n : '0;
			hold_q.nearest_index <= best_valid_n ? best_index_n : '0;
			hold_q.front_found   <= cone_valid_n;
			hold_q.front_range   <= cone_valid_n ? cone_range_n : '0;
			hold_q.front_index   <= cone_valid_n ? cone_index_n : '0;
			hold_q.danger        <= cone_valid_n && (cone_range_n < danger_distance);
			hold_q.valid_count   <= total_n;
			hold_q.mean_range    <= '0;
			hold_q.point_count   <= q_item.count;
		end
		if (load) begin
			out_data_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	lsno_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_n),
		.divisor  (total_n),
		.ack      (load),
		.status   (div_status),
		.quotient (quotient)
	);

endmodule

// ===== hw/rtl/lidar_scan_nearest_obstacle.sv =====
// Lidar nearest-obstacle scan reducer, top level.
// Input channel (in_valid/in_stall/in_data): one range sample per transaction,
// in_data.last marks the final sample of a scan. Samples are numbered from
// zero inside the block; the index saturates at 4095, the counts at 4096.
// Output channel (out_valid/out_stall/out_data): one result per scan, with the
// nearest valid sample, the nearest one in the front cone (within 15 degrees
// of straight ahead), the danger flag, valid count, mean range, point count.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
// high; index 0 min range, 1 max range, 2 angle step (Q16 deg), 3 danger range.
// Throughput: one sample per cycle while the queue is not full. Samples pass
// through a four-entry queue to the accumulator. The last sample of a scan
// starts a bit-serial divide for the mean; the result register loads once the
// divide is done. Samples of the next scan keep flowing meanwhile, but its
// last sample waits in the queue until the divider is free, so scans that
// arrive faster than a divide finishes are limited by the divider.
// A stalled result holds in its register; the divider then holds its result,
// the next closing sample waits and the queue fills until in_stall rises.
// Reset clears the scan, the queue and the output, and loads the default
// configuration (0 / 12000 mm, 1 degree, 1000 mm).
// Depends on lsno_pkg, lsno_front, lsno_fifo, lsno_back.
module lidar_scan_nearest_obstacle import lsno_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data
);

	cfg_t      cfg_q;
	q_status_t q_status;
	logic      q_push;
	logic      q_pop;
	q_item_t   q_push_item;
	q_item_t   q_pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_valid_range <= RST_MIN_RANGE;
			cfg_q.max_valid_range <= RST_MAX_RANGE;
			cfg_q.angle_step      <= RST_STEP;
			cfg_q.danger_distance <= RST_DANGER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MIN_RANGE:  cfg_q.min_valid_range <= cfg_data[RANGE_W-1:0];
				CFG_MAX_RANGE:  cfg_q.max_valid_range <= cfg_data[RANGE_W-1:0];
				CFG_ANGLE_STEP: cfg_q.angle_step      <= cfg_data;
				CFG_DANGER:     cfg_q.danger_distance <= cfg_data[RANGE_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	lsno_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_status (q_status),
		.q_push   (q_push),
		.q_item   (q_push_item)
	);

	lsno_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.status    (q_status)
	);

	lsno_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_item          (q_pop_item),
		.q_status        (q_status),
		.q_pop           (q_pop),
		.danger_distance (cfg_q.danger_distance),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_status.full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_status.empty))
		else $error("queue read while empty");

	a_danger_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.danger || out_data.front_found))
		else $error("danger without front sample");

	a_empty_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.nearest_found) |->
		(out_data.valid_count == '0 && out_data.mean_range == '0
		&& !out_data.front_found))
		else $error("empty scan reports valid data");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.valid_count <= out_data.point_count))
		else $error("valid count exceeds point count");
`endif

endmodule
